// ----- rtl/core/word_wrap_text_layout_core_macros.svh -----
// Assertion macros shared by the word wrap layout RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef WORD_WRAP_TEXT_LAYOUT_CORE_MACROS_SVH
`define WORD_WRAP_TEXT_LAYOUT_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked on every rising clock edge outside reset.
`define WWTL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked on every rising clock edge outside reset.
`define WWTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define WWTL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define WWTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/core/wwtl_pkg.sv -----
// Shared types and constants for the word wrap text layout core.
// Used by the controller, the datapath and the top level; depends on nothing.
package wwtl_pkg;

   // Character codes of the message stream.
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_DEL     = 8'h7F;
   localparam logic [7:0] CODE_SPLIT   = 8'd96;
   localparam logic [7:0] CODE_OFFSET  = 8'd32;

   // Port widths of the two channels.
   localparam int CHAR_W        = 8;
   localparam int SCREEN_ROW_W  = 5;
   localparam int SCREEN_COL_W  = 5;
   localparam int SCREEN_CODE_W = 7;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_WORD,
      OP_FLUSH_INIT,
      OP_FLUSH_NEXT,
      OP_PUT_BYTE,
      OP_CLR_STORED,
      OP_CLR_WORD,
      OP_NEWLINE,
      OP_SPACE,
      OP_HOME,
      OP_DRAIN
   } op_type;

   // Status flags reported by the datapath.
   typedef struct packed {
      logic is_zero;
      logic is_newline;
      logic is_space;
      logic printable;
      logic end_flag;
      logic row_ok;
      logic undecided;
      logic stored_zero;
      logic flush_last;
      logic word_wraps;
      logic word_holds;
      logic hold_valid;
      logic put_ok;
      logic slot_free;
   } status_type;

endpackage

// ----- rtl/core/wwtl_ctrl.sv -----
// Sequencing state machine of the word wrap text layout core.
// Depends on wwtl_pkg and the assertion macro header.
`include "word_wrap_text_layout_core_macros.svh"

module wwtl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wwtl_pkg::status_type status,
   output wwtl_pkg::op_type     cmd_op
);
   import wwtl_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_WORD,
      S_FLUSH_START,
      S_FLUSH_LOAD,
      S_FLUSH_PUT,
      S_FLUSH_DONE,
      S_PUT_BYTE,
      S_NEWLINE,
      S_SPACE,
      S_TAIL,
      S_HOME,
      S_DRAIN
   } state_type;

   // Where to continue once a held word has been released.
   typedef enum logic [1:0] {
      RET_NEWLINE,
      RET_SPACE,
      RET_END,
      RET_BYTE
   } ret_type;

   state_type state_ff, state_in;
   ret_type   ret_ff, ret_in;
   logic      ready_ff;

   // Next state, return point and datapath operation.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd_op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd_op   = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!status.is_zero && status.row_ok) begin
               if (status.is_newline || status.is_space) begin
                  ret_in   = status.is_newline ? RET_NEWLINE : RET_SPACE;
                  state_in = status.undecided ? S_FLUSH_START : S_FLUSH_DONE;
               end else begin
                  state_in = S_WORD;
               end
            end else begin
               state_in = S_TAIL;
            end
         end
         S_WORD: begin
            cmd_op = OP_WORD;
            if (status.word_wraps) begin
               ret_in   = RET_BYTE;
               state_in = S_FLUSH_START;
            end else if (status.word_holds) begin
               state_in = S_TAIL;
            end else begin
               state_in = S_PUT_BYTE;
            end
         end
         S_FLUSH_START: begin
            cmd_op   = OP_FLUSH_INIT;
            state_in = status.stored_zero ? S_FLUSH_DONE : S_FLUSH_LOAD;
         end
         S_FLUSH_LOAD: begin
            state_in = S_FLUSH_PUT;
         end
         S_FLUSH_PUT: begin
            if (status.put_ok) begin
               cmd_op   = OP_FLUSH_NEXT;
               state_in = status.flush_last ? S_FLUSH_DONE : S_FLUSH_LOAD;
            end
         end
         S_FLUSH_DONE: begin
            if (ret_ff == RET_BYTE) begin
               cmd_op   = OP_CLR_STORED;
               state_in = S_PUT_BYTE;
            end else begin
               cmd_op = OP_CLR_WORD;
               case (ret_ff)
                  RET_NEWLINE: state_in = S_NEWLINE;
                  RET_SPACE:   state_in = S_SPACE;
                  default:     state_in = S_HOME;
               endcase
            end
         end
         S_PUT_BYTE: begin
            if (!status.printable) begin
               state_in = S_TAIL;
            end else if (status.put_ok) begin
               cmd_op   = OP_PUT_BYTE;
               state_in = S_TAIL;
            end
         end
         S_NEWLINE: begin
            cmd_op   = OP_NEWLINE;
            state_in = S_TAIL;
         end
         S_SPACE: begin
            cmd_op   = OP_SPACE;
            state_in = S_TAIL;
         end
         S_TAIL: begin
            if (status.is_zero || status.end_flag) begin
               ret_in   = RET_END;
               state_in = status.undecided ? S_FLUSH_START : S_FLUSH_DONE;
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_HOME: begin
            cmd_op   = OP_HOME;
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!status.hold_valid) begin
               state_in = S_IDLE;
            end else if (status.slot_free) begin
               cmd_op   = OP_DRAIN;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, return point and registered ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= RET_END;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_ready = ready_ff;

   // The last write of a transaction must be delivered before the next one starts.
   `WWTL_ASSERT_IMPLY(a_idle_hold_empty, clock, reset, ready_ff, !status.hold_valid,
      "ready raised while a write is still held")
   // Only a held word or a wrapped word is ever released from the store.
   `WWTL_ASSERT_IMPLY(a_flush_reason, clock, reset, state_ff == S_FLUSH_PUT,
      status.undecided || (ret_ff == RET_BYTE), "store released without reason")
   // One transaction at a time.
   `WWTL_ASSERT_NEXT(a_single_item, clock, reset, req_valid && ready_ff, !ready_ff,
      "ready stayed high after a transaction was accepted")

endmodule

// ----- rtl/core/wwtl_datapath.sv -----
// Position registers, word store and output register of the layout core.
// Depends on wwtl_pkg and the assertion macro header.
`include "word_wrap_text_layout_core_macros.svh"

module wwtl_datapath #(
   parameter int GRID_COLS = 20,
   parameter int GRID_ROWS = 25
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wwtl_pkg::op_type                      cmd_op,
   output wwtl_pkg::status_type                  status,
   input  logic [wwtl_pkg::CHAR_W-1:0]           req_char_byte,
   input  logic                                  req_end_of_message,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [wwtl_pkg::SCREEN_ROW_W-1:0]     rsp_screen_row,
   output logic [wwtl_pkg::SCREEN_COL_W-1:0]     rsp_screen_col,
   output logic [wwtl_pkg::SCREEN_CODE_W-1:0]    rsp_screen_code,
   output logic                                  rsp_run_last
);
   import wwtl_pkg::*;

   localparam int ROW_W = $clog2(GRID_ROWS + 1);
   localparam int COL_W = $clog2(GRID_COLS + 1);
   localparam int LEN_W = $clog2(GRID_COLS + 2);
   localparam int IDX_W = $clog2(GRID_COLS);
   localparam int SUM_W = $clog2(2 * GRID_COLS + 2);

   logic [CHAR_W-1:0]        byte_ff;
   logic                     eom_ff;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic [COL_W-1:0]         col_ff, col_in;
   logic [LEN_W-1:0]         wl_ff, wl_in;
   logic                     und_ff, und_in;
   logic [COL_W-1:0]         stored_ff, stored_in;
   logic [IDX_W-1:0]         flush_idx_ff, flush_idx_in;
   logic [SCREEN_CODE_W-1:0] store_mem [GRID_COLS];
   logic [SCREEN_CODE_W-1:0] rdata_ff;
   logic                     hold_valid_ff, hold_valid_in;
   logic [ROW_W-1:0]         hold_row_ff;
   logic [COL_W-1:0]         hold_col_ff;
   logic [SCREEN_CODE_W-1:0] hold_code_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SCREEN_ROW_W-1:0]  rsp_row_ff;
   logic [SCREEN_COL_W-1:0]  rsp_col_ff;
   logic [SCREEN_CODE_W-1:0] rsp_code_ff;
   logic                     rsp_last_ff;

   logic [CHAR_W-1:0]        byte_code;
   logic [SCREEN_CODE_W-1:0] put_code;
   logic                     printable, row_ok, col_at_edge;
   logic [LEN_W-1:0]         new_wl;
   logic                     new_und;
   logic [COL_W-1:0]         new_stored;
   logic [SUM_W-1:0]         fit_sum;
   logic                     wraps, holds, store_en;
   logic                     put_en, emit, push_en, slot_free;
   logic [ROW_W-1:0]         eff_row;
   logic [COL_W-1:0]         eff_col;

   // Byte classes and screen code of the latched byte.
   assign byte_code = (byte_ff < CODE_SPLIT) ? (byte_ff - CODE_OFFSET) : byte_ff;
   assign printable = (byte_ff >= CHAR_SPACE) && (byte_ff <= CHAR_DEL);
   assign row_ok      = row_ff < ROW_W'(GRID_ROWS);
   assign col_at_edge = col_ff == COL_W'(GRID_COLS);

   // Word length and fit decision for a word byte.
   always_comb begin
      if (wl_ff == '0) begin
         new_wl     = LEN_W'(1);
         new_und    = (col_ff != '0);
         new_stored = '0;
      end else begin
         new_wl     = (wl_ff < LEN_W'(GRID_COLS + 1)) ? (wl_ff + LEN_W'(1)) : wl_ff;
         new_und    = und_ff;
         new_stored = stored_ff;
      end
   end
   assign fit_sum  = SUM_W'(col_ff) + SUM_W'(new_wl);
   assign wraps    = new_und && (fit_sum > SUM_W'(GRID_COLS));
   assign holds    = new_und && !wraps;
   assign store_en = (cmd_op == OP_WORD) && holds && printable &&
                     (new_stored < COL_W'(GRID_COLS));

   // One screen write: wrap at the right edge, drop once the grid is full.
   assign put_en    = (cmd_op == OP_PUT_BYTE) || (cmd_op == OP_FLUSH_NEXT);
   assign put_code  = (cmd_op == OP_FLUSH_NEXT) ? rdata_ff : byte_code[SCREEN_CODE_W-1:0];
   assign eff_row   = col_at_edge ? (row_ff + ROW_W'(1)) : row_ff;
   assign eff_col   = col_at_edge ? '0 : col_ff;
   assign emit      = put_en && row_ok && (eff_row < ROW_W'(GRID_ROWS));
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign push_en   = hold_valid_ff && (emit || (cmd_op == OP_DRAIN));

   // Next values of the layout state.
   always_comb begin
      row_in        = row_ff;
      col_in        = col_ff;
      wl_in         = wl_ff;
      und_in        = und_ff;
      stored_in     = stored_ff;
      flush_idx_in  = flush_idx_ff;
      case (cmd_op)
         OP_WORD: begin
            wl_in = new_wl;
            if (wraps) begin
               row_in    = row_ff + ROW_W'(1);
               col_in    = '0;
               und_in    = 1'b0;
               stored_in = new_stored;
            end else if (holds) begin
               und_in    = 1'b1;
               stored_in = store_en ? (new_stored + COL_W'(1)) : new_stored;
            end else begin
               und_in    = 1'b0;
               stored_in = new_stored;
            end
         end
         OP_FLUSH_INIT: begin
            flush_idx_in = '0;
         end
         OP_FLUSH_NEXT, OP_PUT_BYTE: begin
            if (cmd_op == OP_FLUSH_NEXT) begin
               flush_idx_in = flush_idx_ff + IDX_W'(1);
            end
            if (row_ok) begin
               row_in = eff_row;
               col_in = emit ? (eff_col + COL_W'(1)) : eff_col;
            end
         end
         OP_CLR_STORED: begin
            stored_in = '0;
         end
         OP_CLR_WORD: begin
            und_in    = 1'b0;
            stored_in = '0;
            wl_in     = '0;
         end
         OP_NEWLINE: begin
            row_in = row_ff + ROW_W'(1);
            col_in = '0;
         end
         OP_SPACE: begin
            if ((col_ff != '0) && (col_ff < COL_W'(GRID_COLS))) begin
               col_in = col_ff + COL_W'(1);
            end
         end
         OP_HOME: begin
            row_in = '0;
            col_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Held write and output register valid flags.
   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (emit) begin
         hold_valid_in = 1'b1;
      end else if (cmd_op == OP_DRAIN) begin
         hold_valid_in = 1'b0;
      end
      if (push_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and position registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= '0;
         wl_ff         <= '0;
         und_ff        <= 1'b0;
         stored_ff     <= '0;
         flush_idx_ff  <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         row_ff        <= row_in;
         col_ff        <= col_in;
         wl_ff         <= wl_in;
         und_ff        <= und_in;
         stored_ff     <= stored_in;
         flush_idx_ff  <= flush_idx_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Latched transaction payload.
   always_ff @(posedge clock) begin
      if (cmd_op == OP_LOAD) begin
         byte_ff <= req_char_byte;
         eom_ff  <= req_end_of_message;
      end
   end

   // Word store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (store_en) begin
         store_mem[new_stored[IDX_W-1:0]] <= byte_code[SCREEN_CODE_W-1:0];
      end
      rdata_ff <= store_mem[flush_idx_ff];
   end

   // Held write and output payload.
   always_ff @(posedge clock) begin
      if (emit) begin
         hold_row_ff  <= eff_row;
         hold_col_ff  <= eff_col;
         hold_code_ff <= put_code;
      end
      if (push_en) begin
         rsp_row_ff  <= SCREEN_ROW_W'(hold_row_ff);
         rsp_col_ff  <= SCREEN_COL_W'(hold_col_ff);
         rsp_code_ff <= hold_code_ff;
         rsp_last_ff <= (cmd_op == OP_DRAIN);
      end
   end

   // Status toward the controller.
   always_comb begin
      status.is_zero     = (byte_ff == '0);
      status.is_newline  = (byte_ff == CHAR_NEWLINE);
      status.is_space    = (byte_ff == CHAR_SPACE);
      status.printable   = printable;
      status.end_flag    = eom_ff;
      status.row_ok      = row_ok;
      status.undecided   = und_ff;
      status.stored_zero = (stored_ff == '0);
      status.flush_last  = ((COL_W'(flush_idx_ff) + COL_W'(1)) == stored_ff);
      status.word_wraps  = wraps;
      status.word_holds  = holds;
      status.hold_valid  = hold_valid_ff;
      status.put_ok      = !hold_valid_ff || slot_free;
      status.slot_free   = slot_free;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_screen_row  = rsp_row_ff;
   assign rsp_screen_col  = rsp_col_ff;
   assign rsp_screen_code = rsp_code_ff;
   assign rsp_run_last    = rsp_last_ff;

   // A held write always lies inside the grid.
   `WWTL_ASSERT_IMPLY(a_hold_in_grid, clock, reset, hold_valid_ff,
      (hold_row_ff < ROW_W'(GRID_ROWS)) && (hold_col_ff < COL_W'(GRID_COLS)),
      "held write outside the grid")
   // A held word never stores more codes than it has bytes.
   `WWTL_ASSERT_IMPLY(a_store_count, clock, reset, und_ff,
      (wl_ff != '0) && (SUM_W'(stored_ff) <= SUM_W'(wl_ff)),
      "word store count exceeds word length")
   // A stalled write transaction keeps its valid and payload.
   `WWTL_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid_ff && !rsp_ready,
      rsp_valid_ff && $stable(rsp_row_ff) && $stable(rsp_col_ff) &&
      $stable(rsp_code_ff) && $stable(rsp_last_ff),
      "stalled write changed before it was taken")

endmodule

// ----- rtl/core/word_wrap_text_layout_core.sv -----
// Top level of the word wrap text layout core.
// Depends on wwtl_pkg, wwtl_ctrl and wwtl_datapath.
//
//   Channel  Direction  Handshake             Transaction
//   req_     in         req_valid/req_ready   one message byte and end flag
//   rsp_     out        rsp_valid/rsp_ready   one screen write (row, col, code, last)
//
// A drawn byte steps through load, dispatch, word, put, tail and drain; a held byte skips the put.
// Releasing a held word runs a start step, then a read and a write per stored character, then a done step.
// The sequencing state machine handles one byte at a time; the next byte is taken
// once every write of the current one has reached the output register.
// Reset is synchronous and clears position, word state and both valid flags.
// A stalled output holds the sequencer on its next write; the store is not cleared.

module word_wrap_text_layout_core #(
   parameter int GRID_COLS = 20,
   parameter int GRID_ROWS = 25
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [wwtl_pkg::CHAR_W-1:0]           req_char_byte,
   input  logic                                  req_end_of_message,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [wwtl_pkg::SCREEN_ROW_W-1:0]     rsp_screen_row,
   output logic [wwtl_pkg::SCREEN_COL_W-1:0]     rsp_screen_col,
   output logic [wwtl_pkg::SCREEN_CODE_W-1:0]    rsp_screen_code,
   output logic                                  rsp_run_last
);
   import wwtl_pkg::*;

   op_type     cmd_op;
   status_type status;

   // Sequencer.
   wwtl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd_op    (cmd_op)
   );

   // Layout state, word store and output register.
   wwtl_datapath #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd_op             (cmd_op),
      .status             (status),
      .req_char_byte      (req_char_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_screen_row     (rsp_screen_row),
      .rsp_screen_col     (rsp_screen_col),
      .rsp_screen_code    (rsp_screen_code),
      .rsp_run_last       (rsp_run_last)
   );

endmodule

// ----- tb/sv/word_wrap_text_layout_core_tb.sv -----
// Self-checking testbench for word_wrap_text_layout_core: directed and random message text.
// Depends on wwtl_pkg and the core; a behavioral layout predictor checks every screen write.
module word_wrap_text_layout_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wwtl_pkg::*;

   localparam int GRID_COLS = 20;
   localparam int GRID_ROWS = 25;
   localparam logic [7:0] CHAR_END = 8'h00;
   localparam int DIR_N = 18;
   // Bytes offered in total, directed rows included.
   localparam int TEXT_ITEMS = 110;
   // The last bytes run with both sides at full rate.
   localparam int CALM_ITEMS = 15;
   localparam int LONG_HOLD_AT = 50;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [SCREEN_ROW_W-1:0]  row;
      logic [SCREEN_COL_W-1:0]  col;
      logic [SCREEN_CODE_W-1:0] code;
      logic                     last;
   } screen_write_type;

   typedef struct {
      logic [CHAR_W-1:0] ch;
      logic              eom;
      bit                typed;
      bit                writes;
      screen_write_type  w;
   } text_step_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [CHAR_W-1:0]        req_char_byte = '0;
   logic                     req_end_of_message = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [SCREEN_ROW_W-1:0]  rsp_screen_row;
   logic [SCREEN_COL_W-1:0]  rsp_screen_col;
   logic [SCREEN_CODE_W-1:0] rsp_screen_code;
   logic                     rsp_run_last;

   int  errors = 0;
   int  bytes_sent = 0;
   bit  long_hold_done = 1'b0;

   // Layout state of the predictor.
   int               lay_row = 0;
   int               lay_col = 0;
   int               word_len = 0;
   int               held_count = 0;
   bit               fit_open = 1'b0;
   logic [6:0]       held_codes [GRID_COLS];
   screen_write_type step_writes [$];
   screen_write_type screen_writes_due [$];

   // Directed text; typed expectations only where the write is obvious.
   text_step_type dir_steps [DIR_N] = '{
      '{8'h41, 1'b0, 1'b1, 1'b1, '{5'd0, 5'd0, 7'd33, 1'b1}},
      '{8'h00, 1'b0, 1'b1, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b1, 1'b1, '{5'd0, 5'd0, 7'd127, 1'b1}},
      '{8'hFF, 1'b1, 1'b1, 1'b0, '0},
      '{8'h20, 1'b0, 1'b1, 1'b0, '0},
      '{8'h0A, 1'b0, 1'b1, 1'b0, '0},
      '{8'h60, 1'b0, 1'b1, 1'b1, '{5'd1, 5'd0, 7'd96, 1'b1}},
      '{8'h5F, 1'b0, 1'b1, 1'b1, '{5'd1, 5'd1, 7'd63, 1'b1}},
      '{8'h20, 1'b0, 1'b1, 1'b0, '0},
      '{8'h1F, 1'b0, 1'b0, 1'b0, '0},
      '{8'h62, 1'b0, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, 1'b0, '0},
      '{8'h20, 1'b0, 1'b0, 1'b0, '0},
      '{8'h78, 1'b1, 1'b0, 1'b0, '0},
      '{8'h43, 1'b0, 1'b1, 1'b1, '{5'd0, 5'd0, 7'd35, 1'b1}},
      '{8'h20, 1'b0, 1'b1, 1'b0, '0},
      '{8'h0A, 1'b1, 1'b1, 1'b0, '0},
      '{8'h20, 1'b1, 1'b1, 1'b0, '0}
   };

   word_wrap_text_layout_core #(
      .GRID_COLS(GRID_COLS),
      .GRID_ROWS(GRID_ROWS)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_byte      (req_char_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_screen_row     (rsp_screen_row),
      .rsp_screen_col     (rsp_screen_col),
      .rsp_screen_code    (rsp_screen_code),
      .rsp_run_last       (rsp_run_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit is_drawn(logic [7:0] b);
      return b >= CHAR_SPACE && b <= CHAR_DEL;
   endfunction

   function automatic logic [6:0] screen_code_of(logic [7:0] b);
      return (b < CODE_SPLIT) ? 7'(b - CODE_OFFSET) : b[6:0];
   endfunction

   // One screen write at the current position, wrapping at the right edge.
   function void place_code(logic [6:0] code);
      screen_write_type w;
      if (lay_row >= GRID_ROWS) return;
      if (lay_col >= GRID_COLS) begin
         lay_row++;
         lay_col = 0;
         if (lay_row >= GRID_ROWS) return;
      end
      w.row = 5'(lay_row);
      w.col = 5'(lay_col);
      w.code = code;
      w.last = 1'b0;
      step_writes.push_back(w);
      lay_col++;
   endfunction

   function void release_held();
      for (int i = 0; i < held_count && i < GRID_COLS; i++) place_code(held_codes[i]);
      held_count = 0;
   endfunction

   function void close_word();
      if (fit_open) release_held();
      fit_open = 1'b0;
      held_count = 0;
      word_len = 0;
   endfunction

   // A byte inside a word: held while its fit is open, wrapped once it cannot fit.
   function void take_word_byte(logic [7:0] b);
      if (word_len == 0) begin
         word_len = 1;
         held_count = 0;
         fit_open = (lay_col != 0);
      end else if (word_len < GRID_COLS + 1) begin
         word_len++;
      end
      if (fit_open) begin
         if (lay_col + word_len > GRID_COLS) begin
            lay_row++;
            lay_col = 0;
            fit_open = 1'b0;
            release_held();
         end else begin
            if (is_drawn(b) && held_count < GRID_COLS) begin
               held_codes[held_count] = screen_code_of(b);
               held_count++;
            end
            return;
         end
      end
      if (is_drawn(b)) place_code(screen_code_of(b));
   endfunction

   // Predicts the writes of one byte into step_writes.
   function void predict_layout(logic [7:0] b, logic eom);
      step_writes.delete();
      if (b != CHAR_END && lay_row < GRID_ROWS) begin
         if (b == CHAR_NEWLINE) begin
            close_word();
            lay_row++;
            lay_col = 0;
         end else if (b == CHAR_SPACE) begin
            close_word();
            if (lay_col > 0 && lay_col < GRID_COLS) lay_col++;
         end else begin
            take_word_byte(b);
         end
      end
      if (b == CHAR_END || eom) begin
         close_word();
         lay_row = 0;
         lay_col = 0;
      end
      if (step_writes.size() > 0) step_writes[step_writes.size()-1].last = 1'b1;
   endfunction

   // Offers one byte, waits for its transaction and queues the writes it causes.
   task automatic send_byte(input text_step_type s);
      if (bytes_sent < TEXT_ITEMS - CALM_ITEMS && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_byte <= s.ch;
      req_end_of_message <= s.eom;
      do @(posedge clock); while (!req_ready);
      predict_layout(s.ch, s.eom);
      if (s.typed) begin
         step_writes.delete();
         if (s.writes) step_writes.push_back(s.w);
      end
      foreach (step_writes[i]) screen_writes_due.push_back(step_writes[i]);
      bytes_sent++;
   endtask

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      end
   endtask

   // Compare each write transaction against the oldest expectation.
   always @(posedge clock) begin
      screen_write_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (screen_writes_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected write, expected none, actual row %0d col %0d code %0d",
                     $time, rsp_screen_row, rsp_screen_col, rsp_screen_code);
         end else begin
            w = screen_writes_due.pop_front();
            check_field("screen_row", w.row, rsp_screen_row);
            check_field("screen_col", w.col, rsp_screen_col);
            check_field("screen_code", w.code, rsp_screen_code);
            check_field("run_last", w.last, rsp_run_last);
         end
      end
   end

   // Receiver: random stalls, one long hold-off while text keeps coming, none near the end.
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (bytes_sent >= TEXT_ITEMS - CALM_ITEMS) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if (!long_hold_done && bytes_sent >= LONG_HOLD_AT) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
            if ($urandom_range(0, 2) == 0) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(1, 15)) @(posedge clock);
            end
         end
      end
   end

   // Run limit, well above the slowest legal run.
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      text_step_type rnd;
      int pick;
      int len;
      int sep;
      rnd.typed = 1'b0;
      rnd.writes = 1'b0;
      rnd.w = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_steps[i]) send_byte(dir_steps[i]);

      // Random text: mostly words and separators, with noise and newline bursts.
      while (bytes_sent < TEXT_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 26) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
               rnd.ch = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                                   : 8'($urandom_range(8'h21, 8'h7F));
               rnd.eom = 1'b0;
               send_byte(rnd);
            end
            sep = $urandom_range(0, 19);
            rnd.eom = 1'b0;
            if (sep < 13) begin
               rnd.ch = CHAR_SPACE;
            end else if (sep < 17) begin
               rnd.ch = CHAR_NEWLINE;
            end else if (sep < 19) begin
               rnd.ch = 8'($urandom_range(8'h21, 8'h7F));
               rnd.eom = 1'b1;
            end else begin
               rnd.ch = CHAR_END;
               rnd.eom = 1'($urandom_range(0, 1));
            end
            send_byte(rnd);
         end else if (pick < 85) begin
            rnd.ch = 8'($urandom_range(0, 255));
            rnd.eom = ($urandom_range(0, 7) == 0);
            send_byte(rnd);
         end else if (pick < 93) begin
            rnd.ch = CHAR_SPACE;
            rnd.eom = 1'b0;
            repeat ($urandom_range(1, 4)) send_byte(rnd);
         end else begin
            // A burst of newlines, at times enough to use up every row.
            rnd.ch = CHAR_NEWLINE;
            rnd.eom = 1'b0;
            repeat ($urandom_range(20, 27)) send_byte(rnd);
         end
      end
      req_valid <= 1'b0;

      while (screen_writes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && screen_writes_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/wwtl_pkg.sv
rtl/core/wwtl_ctrl.sv
rtl/core/wwtl_datapath.sv
rtl/core/word_wrap_text_layout_core.sv
tb/sv/word_wrap_text_layout_core_tb.sv
